[sv/dxt_pkg.sv]
// Shared types, constants and arithmetic helpers for the DXT block decoder.
// No dependencies; imported by every module of the decoder.
package dxt_pkg;

  localparam int CFG_DIM_W   = 13;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int COORD_W     = 12;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_ALPHA_MODE   = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  // channel positions inside a palette entry
  localparam int CH_B = 0;
  localparam int CH_G = 1;
  localparam int CH_R = 2;
  localparam int CH_A = 3;

  typedef enum logic [1:0] {
    MODE_DXT1 = 2'd0,
    MODE_DXT3 = 2'd1,
    MODE_DXT5 = 2'd2
  } mode_t;

  typedef struct packed {
    logic [63:0] colour_block;
    logic [63:0] alpha_block;
  } blk_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic               block_done;
  } texel_word_t;

  typedef struct packed {
    logic [1:0]           alpha_mode;
    logic [CFG_DIM_W-1:0] image_width;
    logic [CFG_DIM_W-1:0] image_height;
    logic                 clear;
  } cfg_t;

  typedef logic [2:0][7:0] rgb_t;

  // one classified block, as it waits between front and back
  typedef struct packed {
    mode_t              mode;
    logic               punch;
    logic [COORD_W-1:0] px_base;
    logic [COORD_W-1:0] py_base;
    logic [1:0]         last_x;
    logic [1:0]         last_y;
    logic [31:0]        indices;
    logic [63:0]        alpha_bits;
    rgb_t               c0;
    rgb_t               c1;
    logic [2:0][9:0]    sum_13;
    logic [2:0][9:0]    sum_23;
    logic [2:0][8:0]    sum_12;
    logic               alpha_gt;
    logic [5:0][10:0]   alpha_sum;
  } queue_entry_t;

  function automatic rgb_t widen565(input logic [15:0] c);
    rgb_t w;
    w[CH_R] = {c[15:11], c[15:13]};
    w[CH_G] = {c[10:5], c[10:9]};
    w[CH_B] = {c[4:0], c[4:2]};
    return w;
  endfunction

  // reciprocal multiplies, exact over the ranges the sums can reach
  function automatic logic [7:0] div3(input logic [9:0] s);
    logic [20:0] p;
    p = 21'(s) * 21'd683;
    return p[18:11];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] s);
    logic [24:0] p;
    p = 25'(s) * 25'd13108;
    return p[23:16];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] s);
    logic [24:0] p;
    p = 25'(s) * 25'd9363;
    return p[23:16];
  endfunction

endpackage

[sv/dxt_front.sv]
// Front end: accepts compressed block words, tracks block position, clips
// and prepares the endpoint sums. Depends on dxt_pkg.
module dxt_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dxt_pkg::cfg_t        cfg,
  input  logic                 blk_valid,
  output logic                 blk_ready,
  input  dxt_pkg::blk_word_t   blk,
  input  logic                 q_ready,
  output logic                 q_push,
  output dxt_pkg::queue_entry_t q_entry
);
  import dxt_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CW    = ((DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W) + 1;
  localparam int BCW   = $clog2(MAX_DIM / 4 + 1);
  localparam logic [CW-1:0] MAX_DIM_C = CW'(MAX_DIM);

  logic [BCW-1:0] block_column, block_column_next;
  logic [BCW-1:0] block_row, block_row_next;
  logic [CW-1:0]  wreg, hreg, w, h, bw, bh, bx, by, rem_x, rem_y;
  logic [15:0]    c0, c1;
  logic [7:0]     a0, a1;
  rgb_t           e0, e1;
  mode_t          mode;

  assign blk_ready = q_ready;
  assign q_push    = blk_valid && q_ready;

  assign wreg = CW'(cfg.image_width);
  assign hreg = CW'(cfg.image_height);
  assign w  = (wreg == '0) ? CW'(1) : ((wreg > MAX_DIM_C) ? MAX_DIM_C : wreg);
  assign h  = (hreg == '0) ? CW'(1) : ((hreg > MAX_DIM_C) ? MAX_DIM_C : hreg);
  assign bw = (w + CW'(3)) >> 2;
  assign bh = (h + CW'(3)) >> 2;
  assign bx = CW'({block_column, 2'b00});
  assign by = CW'({block_row, 2'b00});
  assign rem_x = w - bx;
  assign rem_y = h - by;

  assign c0 = blk.colour_block[15:0];
  assign c1 = blk.colour_block[31:16];
  assign a0 = blk.alpha_block[7:0];
  assign a1 = blk.alpha_block[15:8];
  assign e0 = widen565(c0);
  assign e1 = widen565(c1);

  always_comb begin
    unique case (cfg.alpha_mode)
      2'd0:    mode = MODE_DXT1;
      2'd1:    mode = MODE_DXT3;
      default: mode = MODE_DXT5;
    endcase
  end

  always_comb begin
    block_column_next = block_column;
    block_row_next    = block_row;
    if (cfg.clear) begin
      block_column_next = '0;
      block_row_next    = '0;
    end else if (q_push) begin
      if (CW'(block_column) + CW'(1) >= bw) begin
        block_column_next = '0;
        if (CW'(block_row) + CW'(1) >= bh) begin
          block_row_next = '0;
        end else begin
          block_row_next = block_row + BCW'(1);
        end
      end else begin
        block_column_next = block_column + BCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_column <= '0;
      block_row    <= '0;
    end else begin
      block_column <= block_column_next;
      block_row    <= block_row_next;
    end
  end

  always_comb begin
    logic [10:0] wa;
    q_entry          = '0;
    q_entry.mode     = mode;
    q_entry.punch    = (mode == MODE_DXT1) && (c0 <= c1);
    q_entry.px_base  = bx[COORD_W-1:0];
    q_entry.py_base  = by[COORD_W-1:0];
    q_entry.last_x   = (rem_x > CW'(3)) ? 2'd3 : 2'(rem_x - CW'(1));
    q_entry.last_y   = (rem_y > CW'(3)) ? 2'd3 : 2'(rem_y - CW'(1));
    q_entry.indices  = blk.colour_block[63:32];
    q_entry.alpha_bits = blk.alpha_block;
    q_entry.c0       = e0;
    q_entry.c1       = e1;
    for (int i = 0; i < 3; i++) begin
      q_entry.sum_13[i] = 10'({e0[i], 1'b0}) + 10'(e1[i]);
      q_entry.sum_23[i] = 10'(e0[i]) + 10'({e1[i], 1'b0});
      q_entry.sum_12[i] = 9'(e0[i]) + 9'(e1[i]);
    end
    q_entry.alpha_gt = a0 > a1;
    // weights for interpolated alpha: sevenths when a0 > a1, else fifths
    for (int i = 1; i <= 6; i++) begin
      wa = q_entry.alpha_gt ? 11'(7 - i) : 11'(5 - i);
      if (q_entry.alpha_gt || i <= 4) begin
        q_entry.alpha_sum[i-1] = 11'(a0) * wa + 11'(a1) * 11'(i);
      end else begin
        q_entry.alpha_sum[i-1] = '0;
      end
    end
  end

endmodule

[sv/dxt_queue.sv]
// Short queue of classified blocks between the front and back ends.
// Depends on dxt_pkg for the entry type and depth.
module dxt_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  dxt_pkg::queue_entry_t push_entry,
  output logic                  ready,
  input  logic                  pop,
  output logic                  head_valid,
  output dxt_pkg::queue_entry_t head
);
  import dxt_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t     entries [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr, wr_ptr_next, rd_ptr, rd_ptr_next;
  logic [NW-1:0]    count, count_next;

  assign ready      = count != NW'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
    end
    if (push && !pop) begin
      count_next = count + NW'(1);
    end else if (pop && !push) begin
      count_next = count - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != NW'(QUEUE_DEPTH) || pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue read while empty");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == NW'(QUEUE_DEPTH)) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with fill count");
`endif

endmodule

[sv/dxt_back.sv]
// Back end: builds the colour and alpha palettes of a queued block and
// emits its in-image texels one per cycle, unless texel_ready stalls them. Depends on dxt_pkg.
module dxt_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  dxt_pkg::queue_entry_t head,
  output logic                  pop,
  output logic                  texel_valid,
  input  logic                  texel_ready,
  output dxt_pkg::texel_word_t  texel
);
  import dxt_pkg::*;

  typedef struct packed {
    mode_t              mode;
    logic [COORD_W-1:0] px_base;
    logic [COORD_W-1:0] py_base;
    logic [1:0]         last_x;
    logic [1:0]         last_y;
    logic [31:0]        indices;
    logic [63:0]        alpha_bits;
    logic [3:0][3:0][7:0] pal;
    logic [7:0][7:0]    atab;
  } loaded_block_t;

  loaded_block_t lb, lb_next;
  logic          l_valid, l_valid_next;
  logic [1:0]    tx, tx_next, ty, ty_next;
  logic          adv, last;
  texel_word_t   texel_next;
  logic          texel_valid_next;

  assign adv  = l_valid && (!texel_valid || texel_ready);
  assign last = (tx == lb.last_x) && (ty == lb.last_y);
  assign pop  = head_valid && (!l_valid || (adv && last));

  // palette build from the queue head
  always_comb begin
    lb_next            = '0;
    lb_next.mode       = head.mode;
    lb_next.px_base    = head.px_base;
    lb_next.py_base    = head.py_base;
    lb_next.last_x     = head.last_x;
    lb_next.last_y     = head.last_y;
    lb_next.indices    = head.indices;
    lb_next.alpha_bits = head.alpha_bits;
    for (int ch = 0; ch < 3; ch++) begin
      lb_next.pal[0][ch] = head.c0[ch];
      lb_next.pal[1][ch] = head.c1[ch];
      if (head.punch) begin
        lb_next.pal[2][ch] = head.sum_12[ch][8:1];
        lb_next.pal[3][ch] = 8'd0;
      end else begin
        lb_next.pal[2][ch] = div3(head.sum_13[ch]);
        lb_next.pal[3][ch] = div3(head.sum_23[ch]);
      end
    end
    lb_next.pal[0][CH_A] = 8'd255;
    lb_next.pal[1][CH_A] = 8'd255;
    lb_next.pal[2][CH_A] = 8'd255;
    lb_next.pal[3][CH_A] = head.punch ? 8'd0 : 8'd255;

    lb_next.atab[0] = head.alpha_bits[7:0];
    lb_next.atab[1] = head.alpha_bits[15:8];
    for (int i = 1; i <= 6; i++) begin
      lb_next.atab[i+1] = head.alpha_gt ? div7(head.alpha_sum[i-1])
                                        : div5(head.alpha_sum[i-1]);
    end
    if (!head.alpha_gt) begin
      lb_next.atab[6] = 8'd0;
      lb_next.atab[7] = 8'd255;
    end
  end

  // texel select for the current position
  always_comb begin
    logic [3:0] k;
    logic [1:0] ix;
    logic [3:0] nib;
    logic [2:0] code;
    k    = {ty, tx};
    ix   = lb.indices[{k, 1'b0} +: 2];
    nib  = lb.alpha_bits[{k, 2'b00} +: 4];
    code = lb.alpha_bits[6'({k, 1'b0}) + 6'(k) + 6'd16 +: 3];
    texel_next.pixel_x    = lb.px_base + COORD_W'(tx);
    texel_next.pixel_y    = lb.py_base + COORD_W'(ty);
    texel_next.red        = lb.pal[ix][CH_R];
    texel_next.green      = lb.pal[ix][CH_G];
    texel_next.blue       = lb.pal[ix][CH_B];
    texel_next.block_done = last;
    unique case (lb.mode)
      MODE_DXT1: texel_next.alpha = lb.pal[ix][CH_A];
      MODE_DXT3: texel_next.alpha = {nib, nib};
      default:   texel_next.alpha = lb.atab[code];
    endcase
  end

  always_comb begin
    tx_next = tx;
    ty_next = ty;
    if (adv) begin
      if (last) begin
        tx_next = 2'd0;
        ty_next = 2'd0;
      end else if (tx == lb.last_x) begin
        tx_next = 2'd0;
        ty_next = ty + 2'd1;
      end else begin
        tx_next = tx + 2'd1;
      end
    end
    if (pop) begin
      l_valid_next = 1'b1;
    end else if (adv && last) begin
      l_valid_next = 1'b0;
    end else begin
      l_valid_next = l_valid;
    end
    if (adv) begin
      texel_valid_next = 1'b1;
    end else if (texel_ready) begin
      texel_valid_next = 1'b0;
    end else begin
      texel_valid_next = texel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l_valid     <= 1'b0;
      tx          <= 2'd0;
      ty          <= 2'd0;
      texel_valid <= 1'b0;
    end else begin
      l_valid     <= l_valid_next;
      tx          <= tx_next;
      ty          <= ty_next;
      texel_valid <= texel_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      lb <= lb_next;
    end
    if (adv) begin
      texel <= texel_next;
    end
  end

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    l_valid |-> (tx <= lb.last_x && ty <= lb.last_y))
    else $error("texel position beyond clipped block");
  a_block_held: assert property (@(posedge clk) disable iff (rst)
    (texel_valid && !texel.block_done) |-> l_valid)
    else $error("block released before its last texel");
  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    (adv && last) |=> (tx == 2'd0 && ty == 2'd0))
    else $error("texel position not restarted after block end");
`endif

endmodule

[sv/dxt_block_texture_decoder.sv]
// DXT1/DXT3/DXT5 block decoder: one 4x4 compressed block word in, one texel
// word out per cycle while texel_ready is high. A taken block is registered
// in the queue, then in the back end, before its first texel is registered.
// Throughput: one texel per cycle from the single port; 16 per unclipped block.
// rst (synchronous) empties the queue and pipeline, sets mode 0, size 1x1.
module dxt_block_texture_decoder #(
  parameter int MAX_DIM = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              blk_valid,
  output logic                              blk_ready,
  input  dxt_pkg::blk_word_t                blk,
  output logic                              texel_valid,
  input  logic                              texel_ready,
  output dxt_pkg::texel_word_t              texel,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dxt_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [dxt_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [dxt_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import dxt_pkg::*;

  logic [1:0]           alpha_mode;
  logic [CFG_DIM_W-1:0] image_width;
  logic [CFG_DIM_W-1:0] image_height;
  logic                 wr_en;
  logic [1:0]           reg_idx;
  cfg_t                 cfg;
  logic                 q_ready, q_push, q_pop, q_head_valid;
  queue_entry_t         q_entry, q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_mode   <= 2'd0;
      image_width  <= CFG_DIM_W'(1);
      image_height <= CFG_DIM_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ALPHA_MODE:   alpha_mode   <= pwdata[1:0];
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ALPHA_MODE:   prdata = APB_DATA_W'(alpha_mode);
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  // a write to any of the three named registers restarts block placement at the image origin
  assign cfg.alpha_mode   = alpha_mode;
  assign cfg.image_width  = image_width;
  assign cfg.image_height = image_height;
  assign cfg.clear        = wr_en && (reg_idx == REG_ALPHA_MODE ||
                                      reg_idx == REG_IMAGE_WIDTH ||
                                      reg_idx == REG_IMAGE_HEIGHT);

  dxt_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  dxt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .ready      (q_ready),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  dxt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_head_valid),
    .head        (q_head),
    .pop         (q_pop),
    .texel_valid (texel_valid),
    .texel_ready (texel_ready),
    .texel       (texel)
  );

endmodule

[verif/tb_top.sv]
// Testbench for dxt_block_texture_decoder: DXT1/DXT3/DXT5 block words in,
// texel words out, each texel checked against a behavioural predictor.
// Depends on dxt_pkg (sv/dxt_pkg.sv) and the decoder RTL.
`timescale 1ns / 100ps

module tb_top;
  import dxt_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 5;
  localparam int IMG_MAX_DIM    = 4096;
  localparam int DRAIN_SETTLE   = 4;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 40;
  localparam int RANDOM_ITEMS   = 88;
  localparam int MAX_WAIT       = 13;
  // alpha_mode code outside the named modes; decodes as DXT5
  localparam logic [1:0] MODE_OTHER = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic blk_valid;
  logic blk_ready;
  blk_word_t blk;
  logic texel_valid;
  logic texel_ready;
  texel_word_t texel;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  // shadow of the decoder's registers and block position
  logic [1:0] cfg_mode;
  logic [CFG_DIM_W-1:0] cfg_width;
  logic [CFG_DIM_W-1:0] cfg_height;
  int blk_col;
  int blk_row;

  blk_word_t block_queue[$];
  texel_word_t texel_expect_q[$];
  int blocks_pending;
  int texel_errors;
  int texels_seen;
  int send_gap;
  int take_stall;
  bit send_steady;
  bit take_steady;
  int idle_cycles;

  string field_name[7] = '{"pixel_x", "pixel_y", "red", "green", "blue", "alpha",
                           "block_done"};

  always #(CLK_PERIOD / 2) clk = ~clk;

  dxt_block_texture_decoder #(
    .MAX_DIM(IMG_MAX_DIM)
  ) dut (
    .clk(clk),
    .rst(rst),
    .blk_valid(blk_valid),
    .blk_ready(blk_ready),
    .blk(blk),
    .texel_valid(texel_valid),
    .texel_ready(texel_ready),
    .texel(texel),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  function automatic int draw_wait(input bit steady);
    if (steady || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic int clamp_dim(input logic [CFG_DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > IMG_MAX_DIM) return IMG_MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic [CFG_DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_DIM_W'($urandom_range(IMG_MAX_DIM + 1, 8191));
      2: return CFG_DIM_W'(IMG_MAX_DIM);
      3: return CFG_DIM_W'($urandom_range(17, IMG_MAX_DIM - 1));
      default: return CFG_DIM_W'($urandom_range(1, 16));
    endcase
  endfunction

  // Decodes one block word and queues the texels it should produce.
  function automatic void predict_texels(input blk_word_t b);
    int w, h, bw, bh, bx, by, x, y, ix, r5, g6, b5, a0, a1;
    int pal[4][4];
    int atab[8];
    int alph[16];
    logic [15:0] c0, c1, cv;
    mode_t m;
    bit punch, have;
    texel_word_t t, held;
    w = clamp_dim(cfg_width);
    h = clamp_dim(cfg_height);
    bw = (w + 3) / 4;
    bh = (h + 3) / 4;
    c0 = b.colour_block[15:0];
    c1 = b.colour_block[31:16];
    m = (cfg_mode == MODE_OTHER) ? MODE_DXT5 : mode_t'(cfg_mode);
    punch = (m == MODE_DXT1) && (c0 <= c1);
    have = 1'b0;

    if (blk_col >= bw) begin
      blk_col = 0;
      blk_row++;
    end
    if (blk_row >= bh) blk_row = 0;
    bx = blk_col * 4;
    by = blk_row * 4;

    for (int e = 0; e < 2; e++) begin
      cv = e ? c1 : c0;
      r5 = int'(cv[15:11]);
      g6 = int'(cv[10:5]);
      b5 = int'(cv[4:0]);
      pal[e][0] = (r5 << 3) | (r5 >> 2);
      pal[e][1] = (g6 << 2) | (g6 >> 4);
      pal[e][2] = (b5 << 3) | (b5 >> 2);
      pal[e][3] = 255;
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (punch) begin
        pal[2][ch] = (pal[0][ch] + pal[1][ch]) / 2;
        pal[3][ch] = 0;
      end else begin
        pal[2][ch] = (2 * pal[0][ch] + pal[1][ch]) / 3;
        pal[3][ch] = (pal[0][ch] + 2 * pal[1][ch]) / 3;
      end
    end
    pal[2][3] = 255;
    pal[3][3] = punch ? 0 : 255;

    if (m == MODE_DXT3) begin
      for (int k = 0; k < 16; k++) alph[k] = 17 * int'(b.alpha_block[4*k +: 4]);
    end else if (m == MODE_DXT5) begin
      a0 = int'(b.alpha_block[7:0]);
      a1 = int'(b.alpha_block[15:8]);
      atab[0] = a0;
      atab[1] = a1;
      if (a0 > a1) begin
        for (int i = 1; i <= 6; i++) atab[i + 1] = ((7 - i) * a0 + i * a1) / 7;
      end else begin
        for (int i = 1; i <= 4; i++) atab[i + 1] = ((5 - i) * a0 + i * a1) / 5;
        atab[6] = 0;
        atab[7] = 255;
      end
      for (int k = 0; k < 16; k++) alph[k] = atab[int'(b.alpha_block[16 + 3*k +: 3])];
    end

    // hold one texel back so the last in-image one can carry block_done
    for (int k = 0; k < 16; k++) begin
      x = bx + (k % 4);
      y = by + (k / 4);
      if (x < w && y < h) begin
        ix = int'(b.colour_block[32 + 2*k +: 2]);
        t.pixel_x = COORD_W'(x);
        t.pixel_y = COORD_W'(y);
        t.red = 8'(pal[ix][0]);
        t.green = 8'(pal[ix][1]);
        t.blue = 8'(pal[ix][2]);
        t.alpha = (m == MODE_DXT1) ? 8'(pal[ix][3]) : 8'(alph[k]);
        t.block_done = 1'b0;
        if (have) texel_expect_q.push_back(held);
        held = t;
        have = 1'b1;
      end
    end
    held.block_done = 1'b1;
    texel_expect_q.push_back(held);

    blk_col++;
    if (blk_col >= bw) begin
      blk_col = 0;
      blk_row++;
      if (blk_row >= bh) blk_row = 0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    texel_errors++;
    if (texel_errors <= MAX_REPORTS) $display("MISMATCH texel %0d: %s", texels_seen, msg);
  endtask

  task automatic check_texel(input texel_word_t got);
    texel_word_t want;
    logic [COORD_W-1:0] got_f[7];
    logic [COORD_W-1:0] want_f[7];
    if (texel_expect_q.size() == 0) begin
      report_mismatch($sformatf("word at (%0d,%0d) with none expected",
                                got.pixel_x, got.pixel_y));
      return;
    end
    want = texel_expect_q.pop_front();
    got_f = '{got.pixel_x, got.pixel_y, COORD_W'(got.red), COORD_W'(got.green),
              COORD_W'(got.blue), COORD_W'(got.alpha), COORD_W'(got.block_done)};
    want_f = '{want.pixel_x, want.pixel_y, COORD_W'(want.red), COORD_W'(want.green),
               COORD_W'(want.blue), COORD_W'(want.alpha), COORD_W'(want.block_done)};
    for (int f = 0; f < 7; f++) begin
      if (got_f[f] !== want_f[f])
        report_mismatch($sformatf("%s is %0d, expected %0d at (%0d,%0d)", field_name[f],
                                  got_f[f], want_f[f], want.pixel_x, want.pixel_y));
    end
  endtask

  // block word driver: predicts on acceptance, then issues the next word after its gap
  always @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
      blk <= '0;
      send_gap = 0;
    end else begin
      if (blk_valid && blk_ready) begin
        predict_texels(blk);
        blocks_pending--;
      end
      if (!blk_valid || blk_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          blk_valid <= 1'b0;
        end else if (block_queue.size() > 0) begin
          blk <= block_queue.pop_front();
          blk_valid <= 1'b1;
          send_gap = draw_wait(send_steady);
        end else begin
          blk_valid <= 1'b0;
        end
      end
    end
  end

  // texel receiver: checks each word, then stalls for a drawn number of cycles
  always @(posedge clk) begin
    if (rst) begin
      texel_ready <= 1'b0;
      take_stall = 0;
    end else begin
      if (texel_valid && texel_ready) begin
        check_texel(texel);
        texels_seen++;
        take_stall = draw_wait(take_steady);
      end
      if (take_stall > 0) begin
        take_stall--;
        texel_ready <= 1'b0;
      end else begin
        texel_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((blk_valid && blk_ready) || (texel_valid && texel_ready) || psel || rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_block(input logic [63:0] colour, input logic [63:0] alpha);
    blk_word_t b;
    b.colour_block = colour;
    b.alpha_block = alpha;
    blocks_pending++;
    block_queue.push_back(b);
    while (block_queue.size() > 1) @(posedge clk);
  endtask

  // a block counts as pending from send_block until the driver has predicted it
  task automatic wait_drained();
    while (blocks_pending != 0 || texel_expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ALPHA_MODE: cfg_mode = value[1:0];
      REG_IMAGE_WIDTH: cfg_width = value[CFG_DIM_W-1:0];
      REG_IMAGE_HEIGHT: cfg_height = value[CFG_DIM_W-1:0];
      default: ;
    endcase
    blk_col = 0;
    blk_row = 0;
  endtask

  // opaque and punch-through colour blocks over one 2x2-block image, no idling
  task automatic test_dxt1_colour();
    wait_drained();
    send_steady = 1'b1;
    take_steady = 1'b1;
    write_reg(REG_ALPHA_MODE, 32'(MODE_DXT1));
    write_reg(REG_IMAGE_WIDTH, 32'd8);
    write_reg(REG_IMAGE_HEIGHT, 32'd8);
    send_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, {$urandom, $urandom});
    send_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, {$urandom, $urandom});
    send_block({32'h1B1B_1B1B, 16'hA5A5, 16'hA5A5}, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block({32'hFFFF_FFFF, 16'h07E0, 16'hF81F}, 64'h0);
    wait_drained();
    send_steady = 1'b0;
    take_steady = 1'b0;
  endtask

  task automatic test_dxt3_alpha();
    wait_drained();
    write_reg(REG_ALPHA_MODE, 32'(MODE_DXT3));
    send_block({$urandom, $urandom}, 64'h0);
    send_block({$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block({$urandom, $urandom}, 64'hFEDC_BA98_7654_3210);
  endtask

  // both alpha ramps plus equal endpoints, under DXT5 and the unnamed mode code
  task automatic test_dxt5_alpha();
    logic [47:0] codes;
    for (int k = 0; k < 16; k++) codes[3*k +: 3] = 3'(k);
    for (int sel = 0; sel < 2; sel++) begin
      wait_drained();
      write_reg(REG_ALPHA_MODE, sel ? 32'(MODE_OTHER) : 32'(MODE_DXT5));
      send_block({$urandom, $urandom}, {codes, 8'd10, 8'd200});
      send_block({$urandom, $urandom}, {codes, 8'd200, 8'd10});
      send_block({$urandom, $urandom}, {codes, 8'd77, 8'd77});
    end
  endtask

  // right/bottom clipping, image wrap, and sizes at and beyond the limits
  task automatic test_image_clipping();
    wait_drained();
    write_reg(REG_ALPHA_MODE, 32'(MODE_DXT1));
    write_reg(REG_IMAGE_WIDTH, 32'd5);
    write_reg(REG_IMAGE_HEIGHT, 32'd6);
    repeat (5) send_block({$urandom, $urandom}, {$urandom, $urandom});
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 32'd1);
    write_reg(REG_IMAGE_HEIGHT, 32'd1);
    send_block({$urandom, $urandom}, {$urandom, $urandom});
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 32'd0);
    write_reg(REG_IMAGE_HEIGHT, 32'd0);
    send_block({$urandom, $urandom}, {$urandom, $urandom});
    wait_drained();
    write_reg(REG_ALPHA_MODE, 32'(MODE_DXT5));
    write_reg(REG_IMAGE_WIDTH, 32'd8191);
    write_reg(REG_IMAGE_HEIGHT, 32'd8191);
    repeat (2) send_block({$urandom, $urandom}, {$urandom, $urandom});
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 32'(IMG_MAX_DIM));
    write_reg(REG_IMAGE_HEIGHT, 32'(IMG_MAX_DIM));
    send_block({$urandom, $urandom}, {$urandom, $urandom});
  endtask

  // random settings per phase; a phase may end mid-image, so the next phase's writes also clear the position
  task automatic test_random_phases();
    int sent, n;
    logic [63:0] colour, alpha;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      send_steady = ($urandom_range(0, 3) == 0);
      take_steady = ($urandom_range(0, 3) == 0);
      write_reg(REG_ALPHA_MODE, 32'($urandom_range(0, 3)));
      if ($urandom_range(0, 1)) write_reg(REG_IMAGE_WIDTH, 32'(pick_dim()));
      if ($urandom_range(0, 1)) write_reg(REG_IMAGE_HEIGHT, 32'(pick_dim()));
      n = $urandom_range(2, 12);
      for (int i = 0; i < n; i++) begin
        colour = {$urandom, $urandom};
        alpha = {$urandom, $urandom};
        case ($urandom_range(0, 5))
          0: colour[31:16] = colour[15:0];
          1: alpha[15:8] = alpha[7:0];
          default: ;
        endcase
        send_block(colour, alpha);
        if ($urandom_range(0, 15) == 0) wait_drained();
      end
      sent += n;
    end
    send_steady = 1'b0;
    take_steady = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    blk_valid <= 1'b0;
    blk <= '0;
    texel_ready <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cfg_mode = MODE_DXT1;
    cfg_width = 1;
    cfg_height = 1;
    blk_col = 0;
    blk_row = 0;
    blocks_pending = 0;
    texel_errors = 0;
    texels_seen = 0;
    idle_cycles = 0;
    send_steady = 1'b0;
    take_steady = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_dxt1_colour();
    test_dxt3_alpha();
    test_dxt5_alpha();
    test_image_clipping();
    test_random_phases();
    wait_drained();

    if (texel_errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
sv/dxt_pkg.sv
sv/dxt_front.sv
sv/dxt_queue.sv
sv/dxt_back.sv
sv/dxt_block_texture_decoder.sv
verif/tb_top.sv
